// ===== sv/shbf_pkg.sv =====
// Shared types and constants for the single-hash Bloom filter.
// Used by shbf_arith and single_hash_bloom_filter; depends on nothing else.

package shbf_pkg;

  localparam int unsigned MaxWordsDef = 1024;
  localparam int unsigned CfgW        = 11;
  localparam logic [CfgW-1:0] CfgReset = 11'd1024;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned HashW    = 64;
  localparam int unsigned BitSelW  = 6;
  localparam int unsigned MixSteps = 7;
  localparam int unsigned DivSteps = 64;

  localparam int unsigned ShA = 21;
  localparam int unsigned ShB = 24;
  localparam int unsigned ShC = 14;
  localparam int unsigned ShD = 28;
  localparam int unsigned ShE = 31;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_MIX,
    ST_DIV,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       load;
    logic       mix;
    logic       div;
    logic [2:0] mix_step;
  } arith_ctrl_t;

endpackage

// ===== sv/single_hash_bloom_filter.sv =====
// Top level of the single-hash Bloom filter: sequencer, bit store and stream ports.
// Depends on shbf_pkg and shbf_arith.

// After reset the block sweeps the bit store to zero, one word a cycle, and takes no
// request meanwhile; configuration writes are taken at any time. An insert or query
// then runs the hash rounds and the bit-serial remainder in the shared arithmetic unit,
// followed by a read and an update of the single-port bit store. A clear sweeps the
// words in use to zero, and an unused request type goes straight to the result. One
// request is in flight at a time; the next beat is accepted while the previous result
// waits in the output register.

module single_hash_bloom_filter #(
  parameter int unsigned MAX_WORDS = shbf_pkg::MaxWordsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [shbf_pkg::CfgW-1:0] cfg_wdata_i,    // words_in_use
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [31:0]               s_axis_tdata_i, // [31:0] key
  input  logic [1:0]                s_axis_tuser_i, // [1:0] req_type
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [7:0]                m_axis_tdata_o  // [0] present, [7:1] zero
);

  localparam int unsigned NW = $clog2(MAX_WORDS + 1);
  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(MAX_WORDS - 1);

  shbf_pkg::state_e      state_q, state_d;
  logic [5:0]            step_q, step_d;
  logic [AW-1:0]         wc_q, wc_d;
  logic [1:0]            req_q, req_d;
  logic [NW-1:0]         n_q, n_d;
  logic                  present_q, present_d;
  logic [shbf_pkg::CfgW-1:0] cfg_q;
  logic                  out_valid_q;
  logic [7:0]            out_data_q;

  logic [63:0]           mem [MAX_WORDS];
  logic [63:0]           rd_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [63:0]           mem_wdata;

  shbf_pkg::arith_ctrl_t ctrl;
  logic [AW-1:0]         word_idx;
  logic [5:0]            bit_sel;
  logic [63:0]           mask;
  logic [31:0]           cfg_ext;
  logic [31:0]           eff32;
  logic [NW-1:0]         eff_n;
  logic                  accept;
  logic                  out_load;

  assign cfg_ext = {{(32 - shbf_pkg::CfgW){1'b0}}, cfg_q};
  always_comb begin
    priority if (cfg_q == '0) begin
      eff32 = 32'd1;
    end else if (cfg_ext > MAX_WORDS) begin
      eff32 = 32'(MAX_WORDS);
    end else begin
      eff32 = cfg_ext;
    end
  end
  assign eff_n = eff32[NW-1:0];

  assign mask = 64'd1 << bit_sel;

  shbf_arith #(
    .MAX_WORDS(MAX_WORDS)
  ) u_arith (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .key_i      (s_axis_tdata_i),
    .words_i    (n_q),
    .word_idx_o (word_idx),
    .bit_sel_o  (bit_sel)
  );

  // Next state
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    wc_d      = wc_q;
    req_d     = req_q;
    n_d       = n_q;
    present_d = present_q;
    unique case (state_q)
      shbf_pkg::ST_INIT: begin
        wc_d = wc_q + 1'b1;
        if (wc_q == LastAddr) begin
          state_d = shbf_pkg::ST_IDLE;
        end
      end
      shbf_pkg::ST_IDLE: begin
        if (accept) begin
          n_d       = eff_n;
          req_d     = s_axis_tuser_i;
          present_d = 1'b0;
          wc_d      = '0;
          step_d    = '0;
          unique case (s_axis_tuser_i)
            shbf_pkg::REQ_CLEAR:  state_d = shbf_pkg::ST_CLEAR;
            shbf_pkg::REQ_INSERT: state_d = shbf_pkg::ST_MIX;
            shbf_pkg::REQ_QUERY:  state_d = shbf_pkg::ST_MIX;
            default:              state_d = shbf_pkg::ST_DONE;
          endcase
        end
      end
      shbf_pkg::ST_CLEAR: begin
        wc_d = wc_q + 1'b1;
        if (NW'(wc_q) == n_q - 1'b1) begin
          state_d = shbf_pkg::ST_DONE;
        end
      end
      shbf_pkg::ST_MIX: begin
        step_d = step_q + 1'b1;
        if (step_q == 6'(shbf_pkg::MixSteps - 1)) begin
          step_d  = '0;
          state_d = shbf_pkg::ST_DIV;
        end
      end
      shbf_pkg::ST_DIV: begin
        step_d = step_q + 1'b1;
        if (step_q == 6'(shbf_pkg::DivSteps - 1)) begin
          state_d = shbf_pkg::ST_READ;
        end
      end
      shbf_pkg::ST_READ: begin
        state_d = shbf_pkg::ST_UPDATE;
      end
      shbf_pkg::ST_UPDATE: begin
        present_d = (req_q == shbf_pkg::REQ_QUERY) && rd_q[bit_sel];
        state_d   = shbf_pkg::ST_DONE;
      end
      shbf_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = shbf_pkg::ST_IDLE;
        end
      end
      default: state_d = shbf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready_o = (state_q == shbf_pkg::ST_IDLE);
    accept          = s_axis_tvalid_i && s_axis_tready_o;
    ctrl.load       = accept;
    ctrl.mix        = (state_q == shbf_pkg::ST_MIX);
    ctrl.div        = (state_q == shbf_pkg::ST_DIV);
    ctrl.mix_step   = step_q[2:0];
    out_load        = (state_q == shbf_pkg::ST_DONE) && (!out_valid_q || m_axis_tready_i);
    mem_addr        = word_idx;
    mem_we          = 1'b0;
    mem_wdata       = '0;
    unique case (state_q)
      shbf_pkg::ST_INIT, shbf_pkg::ST_CLEAR: begin
        mem_addr = wc_q;
        mem_we   = 1'b1;
      end
      shbf_pkg::ST_UPDATE: begin
        mem_we    = (req_q == shbf_pkg::REQ_INSERT);
        mem_wdata = rd_q | mask;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shbf_pkg::ST_INIT;
      step_q      <= '0;
      wc_q        <= '0;
      req_q       <= shbf_pkg::REQ_CLEAR;
      n_q         <= '0;
      present_q   <= 1'b0;
      cfg_q       <= shbf_pkg::CfgReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      wc_q      <= wc_d;
      req_q     <= req_d;
      n_q       <= n_d;
      present_q <= present_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {7'b0, present_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[mem_addr];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // The sweep after reset must finish before any beat is taken.
  a_no_accept_in_init : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == shbf_pkg::ST_INIT) |-> !s_axis_tready_o)
    else $error("input beat offered ready during the reset sweep");

  // A new result appears only out of the completion state.
  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == shbf_pkg::ST_DONE))
    else $error("result raised outside the completion state");

  // Request-driven writes stay inside the words in use.
  a_write_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q != shbf_pkg::ST_INIT)) |-> (NW'(mem_addr) < n_q))
    else $error("bit store written beyond the words in use");

endmodule

// ===== sv/shbf_arith.sv =====
// Shared arithmetic unit: one hash round per cycle, then one remainder bit per cycle.
// Depends on shbf_pkg; driven by the sequencer in single_hash_bloom_filter.

module shbf_arith #(
  parameter int unsigned MAX_WORDS = shbf_pkg::MaxWordsDef,
  localparam int unsigned NW = $clog2(MAX_WORDS + 1),
  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
  localparam int unsigned DW = NW + shbf_pkg::BitSelW
) (
  input  logic                            clk_i,
  input  shbf_pkg::arith_ctrl_t           ctrl_i,
  input  logic [shbf_pkg::KeyW-1:0]       key_i,
  input  logic [NW-1:0]                   words_i,
  output logic [AW-1:0]                   word_idx_o,
  output logic [shbf_pkg::BitSelW-1:0]    bit_sel_o
);

  logic [shbf_pkg::HashW-1:0] v_q, v_d, v_mix;
  logic [DW-1:0]              rem_q, rem_d;
  logic [DW-1:0]              divisor;
  logic [DW:0]                rem_sh;
  logic [DW:0]                rem_sub;

  assign divisor = {words_i, {shbf_pkg::BitSelW{1'b0}}};

  always_comb begin
    unique case (ctrl_i.mix_step)
      3'd0:    v_mix = (~v_q) + (v_q << shbf_pkg::ShA);
      3'd1:    v_mix = v_q ^ (v_q >> shbf_pkg::ShB);
      3'd2:    v_mix = (v_q + (v_q << 3)) + (v_q << 8);
      3'd3:    v_mix = v_q ^ (v_q >> shbf_pkg::ShC);
      3'd4:    v_mix = (v_q + (v_q << 2)) + (v_q << 4);
      3'd5:    v_mix = v_q ^ (v_q >> shbf_pkg::ShD);
      3'd6:    v_mix = v_q + (v_q << shbf_pkg::ShE);
      default: v_mix = v_q;
    endcase
  end

  assign rem_sh  = {rem_q, v_q[shbf_pkg::HashW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_comb begin
    v_d   = v_q;
    rem_d = rem_q;
    priority if (ctrl_i.load) begin
      v_d   = {{(shbf_pkg::HashW - shbf_pkg::KeyW){key_i[shbf_pkg::KeyW-1]}}, key_i};
      rem_d = '0;
    end else if (ctrl_i.mix) begin
      v_d = v_mix;
    end else if (ctrl_i.div) begin
      v_d = {v_q[shbf_pkg::HashW-2:0], 1'b0};
      if (rem_sh >= {1'b0, divisor}) begin
        rem_d = rem_sub[DW-1:0];
      end else begin
        rem_d = rem_sh[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    rem_q <= rem_d;
  end

  assign word_idx_o = rem_q[shbf_pkg::BitSelW +: AW];
  assign bit_sel_o  = rem_q[shbf_pkg::BitSelW-1:0];

endmodule

// ===== dv/tb_single_hash_bloom_filter.sv =====
// Self-checking testbench for single_hash_bloom_filter: directed and random request beats
// are checked against a behavioural model of the hashed bit store, under several sizes.
// Depends on shbf_pkg and the single_hash_bloom_filter RTL.

module tb_single_hash_bloom_filter;

  localparam int unsigned MaxWords   = shbf_pkg::MaxWordsDef;
  localparam logic [1:0]  ReqUnused  = 2'd3;
  localparam int          CycleLimit = 8_000_000;
  localparam int          LongHold   = 400;
  localparam int          SettleCyc  = 100;

  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] key;
  } bloom_req_t;

  typedef struct packed {
    logic        present;
    logic [1:0]  req;
    logic [31:0] key;
  } bloom_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [shbf_pkg::CfgW-1:0] cfg_wdata_i = '0;
  logic                      s_axis_tvalid_i = 1'b0;
  logic                      s_axis_tready_o;
  logic [31:0]               s_axis_tdata_i = '0;
  logic [1:0]                s_axis_tuser_i = '0;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i = 1'b0;
  logic [7:0]                m_axis_tdata_o;

  bloom_req_t                pending_q[$];
  bloom_result_t             expected_q[$];
  logic [31:0]               key_pool[$];
  logic [63:0]               filter_words[MaxWords];
  logic [shbf_pkg::CfgW-1:0] words_mirror = shbf_pkg::CfgReset;

  int          cycle_count = 0;
  int          fault_count = 0;
  int          beats_in = 0;
  int          tx_beats_seen = 0;
  int          tx_gap_left = 0;
  bit          tx_offering = 1'b0;
  bloom_req_t  tx_item;
  bit          sender_idle_on = 1'b0;
  bit          receiver_idle_on = 1'b0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          rx_hold_left = 0;
  int          rx_stall_left = 0;
  logic        rx_ready;
  bloom_result_t exp_res;

  single_hash_bloom_filter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] scramble_key(input logic [63:0] v);
    v = ~v + (v << shbf_pkg::ShA);
    v = v ^ (v >> shbf_pkg::ShB);
    v = (v + (v << 3)) + (v << 8);
    v = v ^ (v >> shbf_pkg::ShC);
    v = (v + (v << 2)) + (v << 4);
    v = v ^ (v >> shbf_pkg::ShD);
    v = v + (v << shbf_pkg::ShE);
    return v;
  endfunction

  // Applies one request to the model store and returns the expected present flag.
  function automatic logic filter_outcome(input bloom_req_t r);
    logic [shbf_pkg::CfgW-1:0] n;
    logic [63:0]               h;
    logic [63:0]               idx;
    int unsigned               w;
    n = words_mirror;
    if (n == 0) n = shbf_pkg::CfgW'(1);
    else if (n > MaxWords) n = shbf_pkg::CfgW'(MaxWords);
    if (r.req == shbf_pkg::REQ_CLEAR) begin
      for (int i = 0; i < int'(n); i++) filter_words[i] = '0;
      return 1'b0;
    end
    if (r.req != shbf_pkg::REQ_INSERT && r.req != shbf_pkg::REQ_QUERY) return 1'b0;
    h = scramble_key({{32{r.key[31]}}, r.key});
    idx = h % (64'(n) << shbf_pkg::BitSelW);
    w = int'(idx >> shbf_pkg::BitSelW);
    if (w >= MaxWords) w = MaxWords - 1;
    if (r.req == shbf_pkg::REQ_INSERT) begin
      filter_words[w][idx[5:0]] = 1'b1;
      return 1'b0;
    end
    return filter_words[w][idx[5:0]];
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h0000_0000;
    if (r < 6) return 32'hFFFF_FFFF;
    if (r < 8) return 32'h7FFF_FFFF;
    if (r < 10) return 32'h8000_0000;
    return $urandom;
  endfunction

  task automatic queue_item(input logic [1:0] req, input logic [31:0] key);
    bloom_req_t item;
    item.req = req;
    item.key = key;
    pending_q.push_back(item);
    if (req == shbf_pkg::REQ_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > 64) void'(key_pool.pop_front());
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || tx_offering || expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_words(input logic [shbf_pkg::CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly inserts and queries, the queries often of recently inserted keys, with some clears and
  // unused request types mixed in.
  task automatic run_random_phase(input logic [shbf_pkg::CfgW-1:0] words, input int count,
                                  input bit tx_idle, input bit rx_idle, input bit long_hold);
    int r;
    logic [31:0] k;
    wait_drained();
    write_words(words);
    sender_idle_on   = tx_idle;
    receiver_idle_on = rx_idle;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (key_pool.size() != 0 && $urandom_range(0, 99) < 60)
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else
        k = pick_key();
      if (r < 3) queue_item(shbf_pkg::REQ_CLEAR, k);
      else if (r < 6) queue_item(ReqUnused, k);
      else if (r < 50) queue_item(shbf_pkg::REQ_INSERT, (r < 35) ? pick_key() : k);
      else queue_item(shbf_pkg::REQ_QUERY, k);
    end
    if (long_hold) hold_requests++;
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      tx_offering = 1'b0;
    end else begin
      if (tx_offering && beats_in != tx_beats_seen) begin
        tx_beats_seen = beats_in;
        tx_offering   = 1'b0;
      end
      if (!tx_offering) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (pending_q.size() != 0) begin
          tx_item = pending_q.pop_front();
          s_axis_tdata_i <= tx_item.key;
          s_axis_tuser_i <= tx_item.req;
          tx_offering = 1'b1;
          tx_gap_left = (sender_idle_on && $urandom_range(0, 99) < 30) ? gap_length() : 0;
        end
      end
    end
    s_axis_tvalid_i <= tx_offering;
  end

  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served  = hold_requests;
      rx_hold_left = LongHold;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      rx_ready = 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      rx_ready = 1'b0;
    end else begin
      rx_ready = 1'b1;
      if (receiver_idle_on && $urandom_range(0, 99) < 25) rx_stall_left = gap_length();
    end
    m_axis_tready_i <= rx_ready && rst_ni;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_single_hash_bloom_filter: errors");
      $finish;
    end else if (rst_ni) begin
      if (cfg_we_i) words_mirror = cfg_wdata_i;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("Result beat with nothing expected: tdata %h", m_axis_tdata_o);
        end else begin
          exp_res = expected_q.pop_front();
          if (m_axis_tdata_o[0] !== exp_res.present || m_axis_tdata_o[7:1] !== 7'd0) begin
            fault_count++;
            if (fault_count <= 10)
              $display("Mismatch: req %0d key %h present expected %b got %b (tdata %h)",
                       exp_res.req, exp_res.key, exp_res.present, m_axis_tdata_o[0],
                       m_axis_tdata_o);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        exp_res.req     = s_axis_tuser_i;
        exp_res.key     = s_axis_tdata_i;
        exp_res.present = filter_outcome('{req: s_axis_tuser_i, key: s_axis_tdata_i});
        expected_q.push_back(exp_res);
        beats_in <= beats_in + 1;
      end
    end
  end

  initial begin
    foreach (filter_words[i]) filter_words[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Out-of-range size saturates to the full store.
    write_words(11'h7FF);
    queue_item(shbf_pkg::REQ_CLEAR, 32'h0000_0000);
    queue_item(shbf_pkg::REQ_INSERT, 32'h0000_0000);
    queue_item(shbf_pkg::REQ_QUERY, 32'h0000_0000);
    queue_item(shbf_pkg::REQ_INSERT, 32'hFFFF_FFFF);
    queue_item(shbf_pkg::REQ_QUERY, 32'hFFFF_FFFF);
    queue_item(shbf_pkg::REQ_INSERT, 32'h7FFF_FFFF);
    queue_item(shbf_pkg::REQ_QUERY, 32'h7FFF_FFFF);
    queue_item(shbf_pkg::REQ_INSERT, 32'h8000_0000);
    queue_item(shbf_pkg::REQ_QUERY, 32'h8000_0000);
    queue_item(shbf_pkg::REQ_QUERY, 32'h0000_0001);
    queue_item(ReqUnused, 32'h0000_0005);
    queue_item(shbf_pkg::REQ_QUERY, 32'h0000_0005);
    queue_item(shbf_pkg::REQ_CLEAR, 32'hFFFF_FFFF);
    queue_item(shbf_pkg::REQ_QUERY, 32'h0000_0000);
    queue_item(shbf_pkg::REQ_QUERY, 32'hFFFF_FFFF);
    queue_item(ReqUnused, 32'h8000_0000);
    wait_drained();

    // A size of zero behaves as a single word.
    write_words(11'd0);
    queue_item(shbf_pkg::REQ_INSERT, 32'h0000_0000);
    queue_item(shbf_pkg::REQ_QUERY, 32'h0000_0000);
    queue_item(shbf_pkg::REQ_QUERY, 32'h1234_5678);
    queue_item(shbf_pkg::REQ_QUERY, 32'hDEAD_BEEF);
    queue_item(shbf_pkg::REQ_CLEAR, 32'h0000_0000);
    queue_item(shbf_pkg::REQ_QUERY, 32'h0000_0000);
    queue_item(shbf_pkg::REQ_INSERT, 32'h8000_0000);
    queue_item(shbf_pkg::REQ_QUERY, 32'h8000_0000);
    wait_drained();

    run_random_phase(11'd1024, 250, 1'b1, 1'b1, 1'b0);
    run_random_phase(11'd2, 150, 1'b0, 1'b0, 1'b0);
    run_random_phase(11'd1023, 250, 1'b1, 1'b0, 1'b0);
    run_random_phase(11'h7FF, 200, 1'b0, 1'b1, 1'b0);
    run_random_phase(11'd1, 150, 1'b0, 1'b1, 1'b1);
    run_random_phase(11'd0, 100, 1'b1, 1'b1, 1'b0);
    run_random_phase(11'd64, 200, 1'b1, 1'b1, 1'b1);
    run_random_phase(11'd300, 200, 1'b0, 1'b0, 1'b0);
    run_random_phase(11'd5, 150, 1'b1, 1'b1, 1'b0);
    run_random_phase(shbf_pkg::CfgW'($urandom_range(0, 2047)), 100, 1'b1, 1'b1, 1'b0);

    wait_drained();
    repeat (SettleCyc) @(posedge clk_i);
    if (fault_count == 0 && expected_q.size() == 0) begin
      $display("tb_single_hash_bloom_filter: clean");
    end else begin
      $display("tb_single_hash_bloom_filter: errors");
    end
    $finish;
  end

endmodule
